>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL of the cipher block.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> rtl/fbc_pkg.sv
// Shared types, operation codes, S-box table and round function of the
// Feistel block cipher. No dependencies.
package fbc_pkg;

  typedef enum logic [1:0] {
    OP_LOAD_KEY   = 2'd0,
    OP_LOAD_CHAIN = 2'd1,
    OP_ENCRYPT    = 2'd2,
    OP_DECRYPT    = 2'd3
  } op_t;

  localparam int unsigned ROT_AMOUNT = 11;

  // One S-box per nibble position, the least significant nibble first.
  localparam logic [3:0] NIB_BOX [0:15][0:15] = '{
    '{4'hC,4'h4,4'h6,4'h2,4'hA,4'h5,4'hB,4'h9,4'hE,4'h8,4'hD,4'h7,4'h0,4'h3,4'hF,4'h1},
    '{4'h6,4'h8,4'h2,4'h3,4'h9,4'hA,4'h5,4'hC,4'h1,4'hE,4'h4,4'h7,4'hB,4'hD,4'h0,4'hF},
    '{4'hB,4'h3,4'h5,4'h8,4'h2,4'hF,4'hA,4'hD,4'hE,4'h1,4'h7,4'h4,4'hC,4'h9,4'h6,4'h0},
    '{4'hC,4'h8,4'h2,4'h1,4'hD,4'h4,4'hF,4'h6,4'h7,4'h0,4'hA,4'h5,4'h3,4'hE,4'h9,4'hB},
    '{4'h7,4'hF,4'h5,4'hA,4'h8,4'h1,4'h6,4'hD,4'h0,4'h9,4'h3,4'hE,4'hB,4'h4,4'h2,4'hC},
    '{4'h5,4'hD,4'hF,4'h6,4'h9,4'h2,4'hC,4'hA,4'hB,4'h7,4'h8,4'h1,4'h4,4'h3,4'hE,4'h0},
    '{4'h8,4'hE,4'h2,4'h5,4'h6,4'h9,4'h1,4'hC,4'hF,4'h4,4'hB,4'h0,4'hD,4'hA,4'h3,4'h7},
    '{4'h1,4'h7,4'hE,4'hD,4'h0,4'h5,4'h8,4'h3,4'h4,4'hF,4'hA,4'h6,4'h9,4'hC,4'hB,4'h2},
    '{4'h4,4'hA,4'h9,4'h2,4'hD,4'h8,4'h0,4'hE,4'h6,4'hB,4'h1,4'hC,4'h7,4'hF,4'h5,4'h3},
    '{4'hE,4'hB,4'h4,4'hC,4'h6,4'hD,4'hF,4'hA,4'h2,4'h3,4'h8,4'h1,4'h0,4'h7,4'h5,4'h9},
    '{4'h5,4'h8,4'h1,4'hD,4'hA,4'h3,4'h4,4'h2,4'hE,4'hF,4'hC,4'h7,4'h6,4'h0,4'h9,4'hB},
    '{4'h7,4'hD,4'hA,4'h1,4'h0,4'h8,4'h9,4'hF,4'hE,4'h4,4'h6,4'hC,4'hB,4'h2,4'h5,4'h3},
    '{4'h6,4'hC,4'h7,4'h1,4'h5,4'hF,4'hD,4'h8,4'h4,4'hA,4'h9,4'hE,4'h0,4'h3,4'hB,4'h2},
    '{4'h4,4'hB,4'hA,4'h0,4'h7,4'h2,4'h1,4'hD,4'h3,4'h6,4'h8,4'h5,4'h9,4'hC,4'hF,4'hE},
    '{4'hD,4'hB,4'h4,4'h1,4'h3,4'hF,4'h5,4'h9,4'h0,4'hA,4'hE,4'h7,4'h6,4'h8,4'h2,4'hC},
    '{4'h1,4'hF,4'hD,4'h0,4'h5,4'h7,4'hA,4'h4,4'h9,4'h2,4'h3,4'hE,4'h6,4'hB,4'h8,4'hC}
  };

  // Nibble substitution followed by a left rotation.
  function automatic logic [63:0] fbc_round(input logic [63:0] v);
    logic [63:0] s;
    s = '0;
    for (int p = 0; p < 16; p++) begin
      s[4*p +: 4] = NIB_BOX[p][v[4*p +: 4]];
    end
    return {s[63-ROT_AMOUNT:0], s[63:64-ROT_AMOUNT]};
  endfunction

endpackage

>>> rtl/feistel_block_cipher_128_cbc.sv
// 128-bit Feistel block cipher in CBC mode, built round a single half-round unit.
// Depends on fbc_pkg and assert_macros.svh.

// Loading a subkey or the chaining value leaves the block in the idle state,
// ready for the next transaction. An encrypt or decrypt transaction keeps
// the input stalled from its acceptance until its result has moved into the
// output register. In the run state one shared adder and S-box layer
// performs one half-round per subkey, using a subkey read from the key memory
// into a register ahead of its half-round. The drain state then moves the
// result into the output register, and waits while an earlier result is
// still held there under stall. The result waits in the output register,
// so a new transaction can be taken before it is collected.
// The subkey memory has no reset; all subkeys must be loaded before use.
module feistel_block_cipher_128_cbc #(
  parameter int unsigned SUBKEY_COUNT = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  logic [1:0]                      op,
  input  logic [$clog2(SUBKEY_COUNT)-1:0] subkey_index,
  input  logic [63:0]                     subkey_value,
  input  logic [63:0]                     word_hi,
  input  logic [63:0]                     word_lo,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [63:0]                     out_hi,
  output logic [63:0]                     out_lo
);
  import fbc_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned KW = $clog2(SUBKEY_COUNT);
  localparam logic [KW-1:0] LAST_STEP = KW'(SUBKEY_COUNT - 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t        state;
  logic [KW-1:0] step;
  logic [KW-1:0] step_inc;
  logic [KW-1:0] rd_addr;
  logic          decrypt;
  logic [63:0]   half_a;
  logic [63:0]   half_b;
  logic [63:0]   key_q;
  logic [63:0]   mask_hi;
  logic [63:0]   mask_lo;
  logic [63:0]   chain_hi;
  logic [63:0]   chain_lo;
  logic [63:0]   f_out;
  logic          accept;
  logic          out_free;
  op_t           op_in;

  logic [63:0] key_mem [SUBKEY_COUNT];

  assign op_in      = op_t'(op);
  assign item_stall = (state != ST_IDLE);
  assign accept     = item_valid && (state == ST_IDLE);
  assign out_free   = !result_valid || !result_stall;
  assign step_inc   = step + KW'(1);

  // The subkey for the next half-round is addressed here and registered in key_q ahead of it.
  always_comb begin
    if (state == ST_IDLE) begin
      rd_addr = (op_in == OP_DECRYPT) ? LAST_STEP : '0;
    end else begin
      rd_addr = decrypt ? (LAST_STEP - step_inc) : step_inc;
    end
  end

  // Even steps update half_b from half_a, odd steps the other way round.
  assign f_out = fbc_round((step[0] ? half_b : half_a) + key_q);

  always_ff @(posedge clk) begin
    if (accept && op_in == OP_LOAD_KEY) begin
      key_mem[subkey_index] <= subkey_value;
    end
    key_q <= key_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      step         <= '0;
      result_valid <= 1'b0;
      chain_hi     <= '0;
      chain_lo     <= '0;
    end else begin
      // In the drain state the output register is refilled below instead.
      if (result_valid && !result_stall && state != ST_DRAIN) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (op_in)
              OP_LOAD_KEY: begin
              end
              OP_LOAD_CHAIN: begin
                chain_hi <= word_hi;
                chain_lo <= word_lo;
              end
              OP_ENCRYPT: begin
                half_a  <= word_hi ^ chain_hi;
                half_b  <= word_lo ^ chain_lo;
                mask_hi <= '0;
                mask_lo <= '0;
                decrypt <= 1'b0;
                step    <= '0;
                state   <= ST_RUN;
              end
              OP_DECRYPT: begin
                // The old chain masks the output; the ciphertext chains on.
                half_a   <= word_hi;
                half_b   <= word_lo;
                mask_hi  <= chain_hi;
                mask_lo  <= chain_lo;
                chain_hi <= word_hi;
                chain_lo <= word_lo;
                decrypt  <= 1'b1;
                step     <= '0;
                state    <= ST_RUN;
              end
              default: begin
              end
            endcase
          end
        end
        ST_RUN: begin
          if (step[0]) begin
            half_a <= half_a ^ f_out;
          end else begin
            half_b <= half_b ^ f_out;
          end
          step <= step_inc;
          if (step == LAST_STEP) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (out_free) begin
            out_hi       <= half_b ^ mask_hi;
            out_lo       <= half_a ^ mask_lo;
            result_valid <= 1'b1;
            if (!decrypt) begin
              chain_hi <= half_b;
              chain_lo <= half_a;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `ASSERT_RST(a_result_from_drain, clk, rst, $rose(result_valid) |-> $past(state == ST_DRAIN), "result appeared without a finished block")
  `ASSERT_RST(a_crypt_starts, clk, rst, (accept && (op_in == OP_ENCRYPT || op_in == OP_DECRYPT)) |=> (state == ST_RUN && step == '0), "cipher transaction did not start at step zero")
  `ASSERT_RST(a_load_stays_idle, clk, rst, (accept && (op_in == OP_LOAD_KEY || op_in == OP_LOAD_CHAIN)) |=> (state == ST_IDLE), "load transaction left the idle state")
  `ASSERT_RST(a_step_advances, clk, rst, (state == ST_RUN && step != LAST_STEP) |=> (state == ST_RUN && step == $past(step_inc)), "half-round counter did not advance")
  `ASSERT_RST(a_drain_holds, clk, rst, (state == ST_DRAIN && result_valid && result_stall) |=> (state == ST_DRAIN), "pending result overwritten")

endmodule

>>> sim/feistel_block_cipher_128_cbc_tb.sv
// Self-checking testbench for the 128-bit CBC Feistel cipher block.
// Depends on fbc_pkg (operation codes) and the RTL of feistel_block_cipher_128_cbc.
module feistel_block_cipher_128_cbc_tb;
  import fbc_pkg::*;

  localparam int KEYS = 64;
  localparam int LAPS = 32;
  localparam int RANDOM_ITEMS = 820;

  // S-box rows in nibble order: entry n sits at bits [63-4n -: 4].
  localparam logic [63:0] SBOX_ROWS [16] = '{
    64'hC462A5B9E8D703F1, 64'h68239A5C1E47BD0F, 64'hB3582FADE174C960,
    64'hC821D4F670A53E9B, 64'h7F5A816D093EB42C, 64'h5DF692CAB78143E0,
    64'h8E25691CF4B0DA37, 64'h17ED05834FA69CB2, 64'h4A92D80E6B1C7F53,
    64'hEB4C6DFA23810759, 64'h581DA342EFC7609B, 64'h7DA1089FE46CB253,
    64'h6C715FD84A9E03B2, 64'h4BA0721D36859CFE, 64'hDB413F590AE7682C,
    64'h1FD057A4923E6B8C
  };

  typedef struct packed {
    op_t         op;
    logic [5:0]  idx;
    logic [63:0] key;
    logic [63:0] hi;
    logic [63:0] lo;
  } cipher_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic [1:0]  op = OP_LOAD_KEY;
  logic [5:0]  subkey_index = '0;
  logic [63:0] subkey_value = '0;
  logic [63:0] word_hi = '0;
  logic [63:0] word_lo = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [63:0] out_hi;
  logic [63:0] out_lo;

  cipher_item_t pending_items [$];
  logic [127:0] expected_blocks [$];
  cipher_item_t cur_item;

  // Mirror of the block's state, advanced as each transaction is accepted.
  logic [KEYS*64-1:0] key_sched = '0;
  logic [63:0]        chain_hi = '0;
  logic [63:0]        chain_lo = '0;

  // Subkeys as they will stand once the queued items so far have been taken.
  logic [KEYS*64-1:0] stim_keys = '0;

  int mismatch_count = 0;
  bit tx_hold;
  int tx_wait = 0;
  int tx_calm = 0;
  int stall_left = 0;
  int open_left = 0;
  int rx_calm = 0;

  feistel_block_cipher_128_cbc dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .op           (op),
    .subkey_index (subkey_index),
    .subkey_value (subkey_value),
    .word_hi      (word_hi),
    .word_lo      (word_lo),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_hi       (out_hi),
    .out_lo       (out_lo)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] mix_half(input logic [63:0] v);
    logic [63:0] s;
    for (int p = 0; p < 16; p++) begin
      s[4*p +: 4] = SBOX_ROWS[p][63 - 4*int'(v[4*p +: 4]) -: 4];
    end
    return {s[52:0], s[63:53]};
  endfunction

  // Returns {hi, lo} of the cipher output for one 128-bit block.
  function automatic logic [127:0] feistel_blocks(input logic [63:0] in_hi,
                                                  input logic [63:0] in_lo,
                                                  input bit inverse,
                                                  input logic [KEYS*64-1:0] keys);
    logic [63:0] a;
    logic [63:0] b;
    int k;
    a = in_hi;
    b = in_lo;
    for (int r = 0; r < LAPS; r++) begin
      k = inverse ? (KEYS - 1 - 2*r) : 2*r;
      b = b ^ mix_half(a + keys[k*64 +: 64]);
      k = inverse ? k - 1 : k + 1;
      a = a ^ mix_half(b + keys[k*64 +: 64]);
    end
    return {b, a};
  endfunction

  task automatic cbc_apply(input cipher_item_t it);
    logic [127:0] r;
    case (it.op)
      OP_LOAD_KEY: begin
        key_sched[int'(it.idx)*64 +: 64] = it.key;
      end
      OP_LOAD_CHAIN: begin
        chain_hi = it.hi;
        chain_lo = it.lo;
      end
      OP_ENCRYPT: begin
        r = feistel_blocks(it.hi ^ chain_hi, it.lo ^ chain_lo, 1'b0, key_sched);
        {chain_hi, chain_lo} = r;
        expected_blocks.push_back(r);
      end
      default: begin
        r = feistel_blocks(it.hi, it.lo, 1'b1, key_sched) ^ {chain_hi, chain_lo};
        chain_hi = it.hi;
        chain_lo = it.lo;
        expected_blocks.push_back(r);
      end
    endcase
  endtask

  task automatic flag_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  // Mostly short gaps, now and then a long one, and calm stretches with none.
  function automatic int next_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) calm = $urandom_range(20, 60);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 120);
  endfunction

  function automatic logic [63:0] pick_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic push_key(input logic [5:0] idx, input logic [63:0] val);
    cipher_item_t it;
    it.op = OP_LOAD_KEY;
    it.idx = idx;
    it.key = val;
    it.hi = pick_word();
    it.lo = pick_word();
    stim_keys[int'(idx)*64 +: 64] = val;
    pending_items.push_back(it);
  endtask

  task automatic push_chain(input logic [63:0] hi, input logic [63:0] lo);
    cipher_item_t it;
    it.op = OP_LOAD_CHAIN;
    it.idx = 6'($urandom_range(0, KEYS - 1));
    it.key = pick_word();
    it.hi = hi;
    it.lo = lo;
    pending_items.push_back(it);
  endtask

  task automatic push_block(input op_t kind, input logic [63:0] hi, input logic [63:0] lo);
    cipher_item_t it;
    it.op = kind;
    it.idx = 6'($urandom_range(0, KEYS - 1));
    it.key = pick_word();
    it.hi = hi;
    it.lo = lo;
    pending_items.push_back(it);
  endtask

  // A CBC message encrypted under a fresh IV, then decrypted again; sometimes
  // the IV reload is skipped or a ciphertext block is corrupted on the way back.
  task automatic push_message(input int len);
    logic [127:0] iv;
    logic [127:0] link;
    logic [127:0] plain;
    logic [127:0] sealed [$];
    iv = {pick_word(), pick_word()};
    link = iv;
    push_chain(iv[127:64], iv[63:0]);
    for (int i = 0; i < len; i++) begin
      plain = {pick_word(), pick_word()};
      link = feistel_blocks(plain[127:64] ^ link[127:64], plain[63:0] ^ link[63:0],
                            1'b0, stim_keys);
      push_block(OP_ENCRYPT, plain[127:64], plain[63:0]);
      sealed.push_back(link);
    end
    if ($urandom_range(0, 9) != 0) push_chain(iv[127:64], iv[63:0]);
    if ($urandom_range(0, 9) == 0) sealed[$urandom_range(0, len - 1)] ^= 128'h1 << $urandom_range(0, 127);
    foreach (sealed[i]) push_block(OP_DECRYPT, sealed[i][127:64], sealed[i][63:0]);
  endtask

  // Driver: presents queued items, predicting each one as it is accepted.
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      tx_hold = item_valid;
      if (item_valid && !item_stall) begin
        cbc_apply(cur_item);
        tx_hold = 1'b0;
      end
      if (!tx_hold) begin
        if (tx_wait > 0) begin
          tx_wait--;
        end else if (pending_items.size() > 0) begin
          cur_item = pending_items.pop_front();
          op <= cur_item.op;
          subkey_index <= cur_item.idx;
          subkey_value <= cur_item.key;
          word_hi <= cur_item.hi;
          word_lo <= cur_item.lo;
          tx_hold = 1'b1;
          tx_wait = next_gap(tx_calm);
        end
      end
      item_valid <= tx_hold;
    end
  end

  // Monitor: checks each accepted result and stalls the output at random.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_blocks.size() == 0) begin
          flag_mismatch($sformatf("result %h_%h with nothing expected", out_hi, out_lo));
        end else begin
          if (out_hi !== expected_blocks[0][127:64])
            flag_mismatch($sformatf("out_hi %h, expected %h", out_hi,
                                    expected_blocks[0][127:64]));
          if (out_lo !== expected_blocks[0][63:0])
            flag_mismatch($sformatf("out_lo %h, expected %h", out_lo,
                                    expected_blocks[0][63:0]));
          void'(expected_blocks.pop_front());
        end
      end
      if (stall_left == 0 && open_left == 0) begin
        stall_left = next_gap(rx_calm);
        open_left = $urandom_range(1, 6);
      end
      if (stall_left > 0) begin
        stall_left--;
        result_stall <= 1'b1;
      end else begin
        open_left--;
        result_stall <= 1'b0;
      end
    end
  end

  initial begin
    int base;
    int pick;
    // Every subkey is written before the first block; the end slots take the extremes.
    push_key(6'd0, '0);
    for (int i = 1; i < KEYS - 1; i++) push_key(i[5:0], pick_word());
    push_key(6'd63, '1);

    // Directed transactions: extreme blocks and chain values, both directions.
    push_block(OP_ENCRYPT, '0, '0);
    push_block(OP_ENCRYPT, '1, '1);
    push_block(OP_DECRYPT, '0, '0);
    push_block(OP_DECRYPT, '1, '1);
    push_chain('1, '1);
    push_block(OP_ENCRYPT, '0, '0);
    push_block(OP_DECRYPT, '1, '0);
    push_chain('0, '0);
    push_block(OP_DECRYPT, '0, '1);
    push_key(6'd5, '1);
    push_block(OP_ENCRYPT, 64'h0123456789ABCDEF, 64'hFEDCBA9876543210);
    push_key(6'd63, '0);
    push_block(OP_DECRYPT, '1, '1);
    push_key(6'd0, '1);
    push_block(OP_ENCRYPT, '1, '0);
    push_message(2);

    base = pending_items.size();
    while (pending_items.size() < base + RANDOM_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick < 12) push_message($urandom_range(0, 3) == 0 ? $urandom_range(4, 8)
                                                             : $urandom_range(1, 3));
      else if (pick < 14) push_key(6'($urandom_range(0, KEYS - 1)), pick_word());
      else if (pick < 15) push_chain(pick_word(), pick_word());
      else push_block($urandom_range(0, 1) ? OP_ENCRYPT : OP_DECRYPT,
                      pick_word(), pick_word());
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Sampled away from the driving edge so that the driver's updates have settled.
    while (pending_items.size() > 0 || item_valid || expected_blocks.size() > 0)
      @(negedge clk);
    repeat (80) @(posedge clk);
    if (expected_blocks.size() != 0) begin
      flag_mismatch($sformatf("%0d results never arrived", expected_blocks.size()));
    end
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

>>> feistel_block_cipher_128_cbc.f
+incdir+rtl
rtl/fbc_pkg.sv
rtl/feistel_block_cipher_128_cbc.sv
sim/feistel_block_cipher_128_cbc_tb.sv
